// File: design/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
// Holds the input and result word structs, status codes and default sizes.
// No dependencies.
package spq_pkg;

    localparam int PRIO_W           = 16;
    localparam int DEPTH_DEF        = 16;
    localparam int PAYLOAD_BITS_DEF = 32;

    // Status codes reported with every result word.
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // Operation codes carried in the mode field.
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    typedef struct packed {
        logic                     mode;
        logic signed [PRIO_W-1:0] priority_req;
        logic [31:0]              payload;
    } t_in;

    typedef struct packed {
        logic [1:0]               status;
        logic                     removed_valid;
        logic signed [PRIO_W-1:0] removed_priority;
        logic [31:0]              removed_payload;
        logic                     empty_res;
        logic                     full_res;
    } t_out;

endpackage

// File: design/spq_store.sv
// Entry memory of the sorted priority queue: one write and one read port.
// The read data is registered. Default sizes come from spq_pkg.
module spq_store #(
    parameter int  DEPTH = spq_pkg::DEPTH_DEF,
    parameter int  DW    = spq_pkg::PRIO_W + spq_pkg::PAYLOAD_BITS_DEF,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/spq_ctrl.sv
// Sequencer of the sorted priority queue: a ring of entries in spq_store,
// walked one entry at a time through a single signed key comparator.
// Depends on spq_pkg.
module spq_ctrl #(
    parameter int  DEPTH        = spq_pkg::DEPTH_DEF,
    parameter int  PAYLOAD_BITS = spq_pkg::PAYLOAD_BITS_DEF,
    localparam int AW           = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW           = $clog2(DEPTH + 1),
    localparam int DW           = spq_pkg::PRIO_W + PAYLOAD_BITS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  spq_pkg::t_in  i_item,
    output logic          o_busy,
    output logic          o_res_valid,
    output spq_pkg::t_out o_res,
    input  logic          i_res_take,
    output logic          o_we,
    output logic [AW-1:0] o_waddr,
    output logic [DW-1:0] o_wdata,
    output logic          o_re,
    output logic [AW-1:0] o_raddr,
    input  logic [DW-1:0] i_rdata
);
    import spq_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_INS_STEP = 3'd1;
    localparam logic [2:0] S_INS_CMP  = 3'd2;
    localparam logic [2:0] S_REM_CMP  = 3'd3;
    localparam logic [2:0] S_DONE     = 3'd4;

    logic [2:0]               r_state, n_state;
    logic [CW-1:0]            r_count, n_count;
    logic [AW-1:0]            r_head, n_head;
    logic [AW-1:0]            r_tail, n_tail;
    logic [AW-1:0]            r_phys, n_phys;
    logic [CW-1:0]            r_left, n_left;
    logic signed [PRIO_W-1:0] r_key, n_key;
    logic [PAYLOAD_BITS-1:0]  r_tag, n_tag;
    t_out                     r_res, n_res;
    logic                     w_fin_ins;
    logic signed [PRIO_W-1:0] w_rd_prio;

    function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [AW-1:0] ring_dec(input logic [AW-1:0] p);
        return (p == '0) ? AW'(DEPTH - 1) : p - 1'b1;
    endfunction

    assign w_rd_prio = i_rdata[DW-1 -: PRIO_W];

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_head    = r_head;
        n_tail    = r_tail;
        n_phys    = r_phys;
        n_left    = r_left;
        n_key     = r_key;
        n_tag     = r_tag;
        n_res     = r_res;
        w_fin_ins = 1'b0;
        o_we      = 1'b0;
        o_waddr   = r_phys;
        o_wdata   = {r_key, r_tag};
        o_re      = 1'b0;
        o_raddr   = ring_dec(r_phys);
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_key = i_item.priority_req;
                    n_tag = PAYLOAD_BITS'(i_item.payload);
                    n_res = '0;
                    if (i_item.mode == MODE_INSERT) begin
                        if (r_count == CW'(DEPTH)) begin
                            n_res.status   = ST_FULL;
                            n_res.full_res = 1'b1;
                            n_state        = S_DONE;
                        end else begin
                            n_phys  = r_tail;
                            n_left  = r_count;
                            n_state = S_INS_STEP;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_res.status    = ST_EMPTY;
                            n_res.empty_res = 1'b1;
                            n_state         = S_DONE;
                        end else begin
                            o_re    = 1'b1;
                            o_raddr = r_head;
                            n_state = S_REM_CMP;
                        end
                    end
                end
            end
            S_INS_STEP: begin
                if (r_left == '0) begin
                    w_fin_ins = 1'b1;
                end else begin
                    o_re    = 1'b1;
                    n_state = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                // A larger stored key moves up one slot; otherwise the new
                // entry lands here, behind every key equal to it.
                if (w_rd_prio > r_key) begin
                    o_we    = 1'b1;
                    o_wdata = i_rdata;
                    n_phys  = ring_dec(r_phys);
                    n_left  = r_left - 1'b1;
                    n_state = S_INS_STEP;
                end else begin
                    w_fin_ins = 1'b1;
                end
            end
            S_REM_CMP: begin
                n_res.status           = ST_DONE;
                n_res.removed_valid    = 1'b1;
                n_res.removed_priority = w_rd_prio;
                n_res.removed_payload  = 32'(i_rdata[PAYLOAD_BITS-1:0]);
                n_res.empty_res        = (r_count == CW'(1));
                n_res.full_res         = 1'b0;
                n_head                 = ring_inc(r_head);
                n_count                = r_count - 1'b1;
                n_state                = S_DONE;
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (w_fin_ins) begin
            o_we           = 1'b1;
            o_waddr        = r_phys;
            o_wdata        = {r_key, r_tag};
            n_count        = r_count + 1'b1;
            n_tail         = ring_inc(r_tail);
            n_res.status   = ST_DONE;
            n_res.empty_res = 1'b0;
            n_res.full_res = (r_count == CW'(DEPTH - 1));
            n_state        = S_DONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_head  <= '0;
            r_tail  <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_head  <= n_head;
            r_tail  <= n_tail;
        end
    end

    always_ff @(posedge i_clk) begin
        r_phys <= n_phys;
        r_left <= n_left;
        r_key  <= n_key;
        r_tag  <= n_tag;
        r_res  <= n_res;
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above depth");

    a_ring_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == CW'(DEPTH)) |-> (r_tail == r_head))
        else $error("ring head and tail disagree with count");

    a_idle_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_DONE) |=> $stable(r_count))
        else $error("count changed outside an operation");

    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INS_STEP || r_state == S_INS_CMP) |-> (r_left <= r_count))
        else $error("insert walk ran past the stored entries");
`endif

endmodule

// File: design/sorted_priority_queue.sv
// Sorted priority queue, smallest priority first, stable among equal keys.
// Top level: input and result channels with a registered result word.
// Depends on spq_pkg, spq_ctrl and spq_store.
//
// Usage: the input channel carries one word per operation: mode 0 inserts
// priority_req with its payload tag, mode 1 removes the smallest entry.
// Every input word yields exactly one result word with a status, the
// removed entry (zero when nothing was removed) and the empty and full
// flags as they stand after the operation.
// The block works on one word at a time. o_in_stall is high from the cycle
// after a word is accepted until its result has moved into the output
// register. A dropped insert or a remove on an empty queue goes straight to
// the result state; a remove first reads the head entry. An insert walks
// back from the tail past every larger stored entry, and each one costs one
// memory read and one compare-and-write. Entries sit in a ring, so a remove
// never moves the others. Reset empties the queue at once; memory contents
// are not cleared and are never read before written. When the receiver
// stalls, the result word holds in the output register; one more result
// waits in the sequencer and the input stays stalled until it moves on.
module sorted_priority_queue #(
    parameter int DEPTH        = spq_pkg::DEPTH_DEF,
    parameter int PAYLOAD_BITS = spq_pkg::PAYLOAD_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  spq_pkg::t_in  i_in_data,
    output logic          o_in_stall,
    output logic          o_out_valid,
    output spq_pkg::t_out o_out_data,
    input  logic          i_out_stall
);
    import spq_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DW = PRIO_W + PAYLOAD_BITS;

    logic          w_busy;
    logic          w_start;
    logic          w_res_valid;
    t_out          w_res;
    logic          w_take;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [DW-1:0] w_wdata;
    logic          w_re;
    logic [AW-1:0] w_raddr;
    logic [DW-1:0] w_rdata;
    logic          r_out_valid;
    t_out          r_out;

    // The input word is taken whenever the sequencer is idle.
    assign o_in_stall = w_busy;
    assign w_start    = i_in_valid && !w_busy;

    // The finished result moves into the output register when it is empty
    // or its word is being taken in this cycle.
    assign w_take = w_res_valid && (!r_out_valid || !i_out_stall);

    spq_ctrl #(
        .DEPTH        (DEPTH),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_item      (i_in_data),
        .o_busy      (w_busy),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .i_res_take  (w_take),
        .o_we        (w_we),
        .o_waddr     (w_waddr),
        .o_wdata     (w_wdata),
        .o_re        (w_re),
        .o_raddr     (w_raddr),
        .i_rdata     (w_rdata)
    );

    spq_store #(
        .DEPTH (DEPTH),
        .DW    (DW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// File: verif/testbench.sv
// Self-checking testbench for sorted_priority_queue: directed and random words
// against a behavioral predictor of the stable min-first queue.
// Depends on spq_pkg and the sorted_priority_queue RTL.
`timescale 1ns / 1ps

module testbench;
    import spq_pkg::*;

    localparam int QDEPTH     = DEPTH_DEF;
    localparam int HOLD_LEN   = 300;  // cycles the receiver refuses words under pressure
    localparam int DRAIN_WAIT = 80;   // longer than the slowest insert

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    t_in  i_in_data   = '0;
    logic o_in_stall;
    logic o_out_valid;
    t_out o_out_data;
    logic i_out_stall = 1'b0;

    sorted_priority_queue dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Shadow copy of the queue contents, kept in ascending key order.
    logic signed [PRIO_W-1:0] shadow_key [QDEPTH];
    logic [31:0]              shadow_tag [QDEPTH];
    int                       shadow_count = 0;

    // Result words still owed by the block, oldest first.
    t_out owed_results [$];
    int   mismatches = 0;

    // When set, neither side idles; used for the back-to-back burst.
    bit   steady = 1'b0;

    // The pressure test bumps hold_orders; the stall process serves each order
    // with a long hold-off that it counts down on its own.
    int   hold_orders = 0;
    int   hold_served = 0;
    int   hold_left   = 0;

    // Advances the shadow queue by one word and returns the result it must cause.
    function automatic t_out predict_queue_step(t_in w);
        t_out r;
        int   pos;
        r = '0;
        r.status = ST_DONE;
        if (w.mode == MODE_INSERT) begin
            if (shadow_count >= QDEPTH) begin
                r.status = ST_FULL;
            end else begin
                // Walk back past every larger key so equal keys stay in arrival order.
                pos = shadow_count;
                while (pos > 0 && shadow_key[pos-1] > w.priority_req) pos--;
                for (int i = shadow_count; i > pos; i--) begin
                    shadow_key[i] = shadow_key[i-1];
                    shadow_tag[i] = shadow_tag[i-1];
                end
                shadow_key[pos] = w.priority_req;
                shadow_tag[pos] = w.payload;
                shadow_count++;
            end
        end else begin
            if (shadow_count == 0) begin
                r.status = ST_EMPTY;
            end else begin
                r.removed_valid    = 1'b1;
                r.removed_priority = shadow_key[0];
                r.removed_payload  = shadow_tag[0];
                for (int i = 1; i < shadow_count; i++) begin
                    shadow_key[i-1] = shadow_key[i];
                    shadow_tag[i-1] = shadow_tag[i];
                end
                shadow_count--;
            end
        end
        r.empty_res = (shadow_count == 0);
        r.full_res  = (shadow_count >= QDEPTH);
        return r;
    endfunction

    function automatic t_in make_word(logic mode, logic [PRIO_W-1:0] key, logic [31:0] tag);
        t_in w;
        w.mode         = mode;
        w.priority_req = key;
        w.payload      = tag;
        return w;
    endfunction

    // Keys cluster in a narrow band often enough to make ties common, hit the
    // two extremes now and then, and otherwise cover the whole 16-bit range.
    function automatic logic [PRIO_W-1:0] pick_key();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 4) return PRIO_W'($urandom_range(0, 8)) - PRIO_W'(4);
        if (pick == 4) return 16'h7FFF;
        if (pick == 5) return 16'h8000;
        return PRIO_W'($urandom());
    endfunction

    function automatic t_in random_word(int insert_pct);
        if ($urandom_range(0, 99) < insert_pct)
            return make_word(MODE_INSERT, pick_key(), $urandom());
        // The key and tag of a remove are don't-care, so they get noise.
        return make_word(MODE_REMOVE, PRIO_W'($urandom()), $urandom());
    endfunction

    // Offers one word and returns once it has been accepted. Valid stays high
    // from one word to the next unless the sender decides to idle first.
    task automatic send_word(t_in w);
        if (!steady) begin
            while ($urandom_range(0, 99) < 29) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        do @(posedge i_clk); while (o_in_stall);
        owed_results.push_back(predict_queue_step(w));
    endtask

    task automatic note_mismatch(string what, longint exp_v, longint got_v);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] MISMATCH %s: expected %0h, got %0h", $realtime, what, exp_v, got_v);
    endtask

    // Receiver: random stalls, none while steady, and long hold-offs on order.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (hold_served != hold_orders) begin
            i_out_stall <= 1'b1;
            hold_left   <= HOLD_LEN;
            hold_served <= hold_served + 1;
        end else begin
            i_out_stall <= !steady && ($urandom_range(0, 99) < 29);
        end
    end

    // Every word that leaves the block is compared with the oldest owed result.
    // Values sampled at the edge are the ones the handshake used.
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (owed_results.size() == 0) begin
                note_mismatch("result word with none owed", 0, o_out_data);
            end else begin
                want = owed_results.pop_front();
                if (o_out_data.status !== want.status)
                    note_mismatch("status", want.status, o_out_data.status);
                if (o_out_data.removed_valid !== want.removed_valid)
                    note_mismatch("removed_valid", want.removed_valid,
                                  o_out_data.removed_valid);
                if (o_out_data.removed_priority !== want.removed_priority)
                    note_mismatch("removed_priority", want.removed_priority,
                                  o_out_data.removed_priority);
                if (o_out_data.removed_payload !== want.removed_payload)
                    note_mismatch("removed_payload", want.removed_payload,
                                  o_out_data.removed_payload);
                if (o_out_data.empty_res !== want.empty_res)
                    note_mismatch("empty_res", want.empty_res, o_out_data.empty_res);
                if (o_out_data.full_res !== want.full_res)
                    note_mismatch("full_res", want.full_res, o_out_data.full_res);
            end
        end
    end

    // A remove right after reset must report the empty queue and change nothing.
    task automatic test_remove_when_empty();
        send_word(make_word(MODE_REMOVE, 16'h8000, 32'hFFFF_FFFF));
    endtask

    // Fills the queue with both key extremes, zero, and runs of equal keys whose
    // tags show the arrival order, then tries one insert more than fits.
    task automatic test_fill_and_overflow();
        logic [PRIO_W-1:0] keys [QDEPTH];
        keys = '{16'h0000, 16'h7FFF, 16'h8000, 16'h0005, 16'h0005, 16'h0005,
                 16'hFFFF, 16'h0001, 16'h7FFF, 16'h8000, 16'h0064, 16'hFF9C,
                 16'h0007, 16'h0003, 16'h0005, 16'h0000};
        for (int i = 0; i < QDEPTH; i++)
            send_word(make_word(MODE_INSERT, keys[i], (i == 0) ? 32'h0 :
                                (i == 1) ? 32'hFFFF_FFFF : 32'hA000_0000 + i));
        // The queue is full now, so this one is dropped.
        send_word(make_word(MODE_INSERT, 16'h8000, 32'h5555_AAAA));
    endtask

    // Pulls a few entries off the front: the two most negative keys must come
    // out in the order they went in.
    task automatic test_remove_front();
        repeat (4) send_word(make_word(MODE_REMOVE, 16'h0000, 32'h0));
    endtask

    // Phases lean toward inserts or removes in turn, so the queue keeps
    // swinging between full and empty with random content in between.
    task automatic test_random_mix(int words);
        int sent;
        int phase_len;
        int insert_pct;
        sent = 0;
        while (sent < words) begin
            phase_len  = $urandom_range(10, 60);
            insert_pct = ($urandom_range(0, 2) == 0) ? 50 : ((sent / 40) % 2 ? 20 : 80);
            for (int i = 0; i < phase_len && sent < words; i++) begin
                send_word(random_word(insert_pct));
                sent++;
            end
        end
    endtask

    // Back-to-back words with neither side idling.
    task automatic test_steady_burst(int words);
        steady = 1'b1;
        for (int i = 0; i < words; i++)
            send_word(random_word((i / 25) % 2 ? 30 : 70));
        steady = 1'b0;
    endtask

    // The receiver holds off for a long stretch while words keep coming, so
    // the output register and the sequencer fill and the input stalls.
    task automatic test_receiver_holdoff(int words);
        hold_orders++;
        for (int i = 0; i < words; i++)
            send_word(random_word(60));
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_remove_when_empty();
        test_fill_and_overflow();
        test_remove_front();
        test_random_mix(700);
        test_steady_burst(150);
        test_receiver_holdoff(40);

        i_in_valid <= 1'b0;
        while (owed_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
